// ----- hw/rtl/vssc_pkg.sv -----
// shared types and constants for the volume scaler and peak meter
package vssc_pkg;

  // volume scale: unity gain is 2^VOLUME_SHIFT
  localparam int VOLUME_SHIFT = 8;

  // datapath widths: 32-bit sample times 10-bit signed volume, plus rounding headroom
  localparam int PROD_W = 42;
  localparam int SUM_W  = 44;

  // right shifts per input width mode
  localparam int SHIFT_MODE16 = 8;
  localparam int SHIFT_MODE24 = 8 + VOLUME_SHIFT;
  localparam int SHIFT_MODE32 = 16 + VOLUME_SHIFT;

  // rounding offsets
  localparam logic signed [SUM_W-1:0] ROUND_PCM = SUM_W'(1) << (VOLUME_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] ROUND_24  = SUM_W'(1) << (SHIFT_MODE24 - 1);
  localparam logic signed [SUM_W-1:0] ROUND_32  = SUM_W'(1) << (SHIFT_MODE32 - 1);

  // input width mode codes
  localparam logic [1:0] MODE_8BIT  = 2'd0;
  localparam logic [1:0] MODE_16BIT = 2'd1;
  localparam logic [1:0] MODE_24BIT = 2'd2;
  localparam logic [1:0] MODE_32BIT = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_INPUT_WIDTH_MODE = 2'd0;
  localparam logic [1:0] REG_VOLUME           = 2'd1;
  localparam logic [1:0] REG_OUT_ALIGN        = 2'd2;

  // reset values of the configuration registers
  localparam logic [1:0] MODE_RESET   = MODE_16BIT;
  localparam logic [8:0] VOLUME_RESET = 9'd256;

  // configuration seen by the lanes and the merge stage
  typedef struct packed {
    logic [1:0] mode;
    logic [8:0] volume;
    logic       left_align;
  } cfg_t;

endpackage

// ----- hw/rtl/vssc_lane.sv -----
// one channel lane: sample select, volume multiply, round and shift to 16 bits
module vssc_lane
  import vssc_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  cfg_t               cfg,
  input  logic [31:0]        sample,
  output logic signed [15:0] v16
);

  logic signed [31:0]       s_ext;
  logic signed [9:0]        vol_s;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [PROD_W-1:0] prod;
  logic                     neg;
  logic signed [SUM_W-1:0]  rnd;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shifted;

  // pick the sample bits for the width mode and multiply by the volume
  always_comb begin
    unique case (cfg.mode)
      MODE_8BIT:  s_ext = {{24{sample[7]}}, sample[7:0]};
      MODE_16BIT: s_ext = {{16{sample[15]}}, sample[15:0]};
      default:    s_ext = sample;
    endcase
    vol_s     = $signed({1'b0, cfg.volume});
    prod_next = s_ext * vol_s;
  end

  // product register
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= prod_next;
      neg  <= s_ext[31];
    end
  end

  // rounding offset, symmetric for the wide modes
  always_comb begin
    unique case (cfg.mode)
      MODE_8BIT:  rnd = ROUND_PCM;
      MODE_16BIT: rnd = ROUND_PCM;
      MODE_24BIT: rnd = neg ? -ROUND_24 : ROUND_24;
      default:    rnd = neg ? -ROUND_32 : ROUND_32;
    endcase
    sum = SUM_W'(prod) + rnd;
  end

  // floor shift down (not in 8-bit mode, which is not shifted) and keep the low 16 bits
  always_comb begin
    unique case (cfg.mode)
      MODE_8BIT:  shifted = sum;
      MODE_16BIT: shifted = sum >>> SHIFT_MODE16;
      MODE_24BIT: shifted = sum >>> SHIFT_MODE24;
      default:    shifted = sum >>> SHIFT_MODE32;
    endcase
    v16 = shifted[15:0];
  end

endmodule

// ----- hw/rtl/vssc_merge.sv -----
// merge stage: per-packet peak hold, output placement and output register
module vssc_merge
  import vssc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  input  logic signed [15:0] left_v16,
  input  logic signed [15:0] right_v16,
  input  cfg_t               cfg,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_last,
  output logic [31:0]        left_out,
  output logic [31:0]        right_out,
  output logic [14:0]        left_level,
  output logic [14:0]        right_level
);

  logic [14:0] left_peak_hold;
  logic [14:0] right_peak_hold;
  logic [14:0] left_peak_next;
  logic [14:0] right_peak_next;
  logic        take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // raise the peaks with this frame's positive values
  always_comb begin
    left_peak_next  = left_peak_hold;
    right_peak_next = right_peak_hold;
    if (left_v16 > $signed({1'b0, left_peak_hold})) begin
      left_peak_next = left_v16[14:0];
    end
    if (right_v16 > $signed({1'b0, right_peak_hold})) begin
      right_peak_next = right_v16[14:0];
    end
  end

  // peak hold, cleared after the last frame of a packet
  always_ff @(posedge clk) begin
    if (rst) begin
      left_peak_hold  <= '0;
      right_peak_hold <= '0;
    end else if (take) begin
      left_peak_hold  <= in_last ? '0 : left_peak_next;
      right_peak_hold <= in_last ? '0 : right_peak_next;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_last    <= in_last;
      left_out    <= cfg.left_align ? {left_v16, 16'b0} : {{16{left_v16[15]}}, left_v16};
      right_out   <= cfg.left_align ? {right_v16, 16'b0} : {{16{right_v16[15]}}, right_v16};
      left_level  <= in_last ? left_peak_next : '0;
      right_level <= in_last ? right_peak_next : '0;
    end
  end

endmodule

// ----- hw/rtl/volume_scale_sample_converter_top.sv -----
// top level: stereo pcm volume scaler with per-packet peak meter
// an input transaction passes the product register and then the output register to become a result transaction
// throughput: one frame per cycle while the output is not stalled, with one 32x10 multiplier per channel lane
// a new frame is taken while a finished result waits, as long as the product stage is free
// reset (rst, synchronous): clears valid bits and peak holds, loads 16-bit mode,
// volume 256 and left-aligned output
module volume_scale_sample_converter_top
  import vssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [8:0]  cfg_wdata,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // left_sample[31:0], right_sample[63:32]
  input  logic        s_tlast,   // end_of_packet
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // left_out[31:0], right_out[63:32], left_level[78:64],
                                 // right_level[93:79], zero [95:94]
  output logic        m_tlast    // frame_last
);

  cfg_t               cfg;
  logic               v1;
  logic               last1;
  logic               en1;
  logic               merge_ready;
  logic signed [15:0] left_v16;
  logic signed [15:0] right_v16;
  logic [31:0]        left_out;
  logic [31:0]        right_out;
  logic [14:0]        left_level;
  logic [14:0]        right_level;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= MODE_RESET;
      cfg.volume     <= VOLUME_RESET;
      cfg.left_align <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_INPUT_WIDTH_MODE: cfg.mode       <= cfg_wdata[1:0];
        REG_VOLUME:           cfg.volume     <= cfg_wdata;
        REG_OUT_ALIGN:        cfg.left_align <= cfg_wdata[0];
        default:              ;
      endcase
    end
  end

  // product stage handshake
  assign en1      = !v1 || merge_ready;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      last1 <= s_tlast;
    end
  end

  // one lane per channel
  vssc_lane u_lane_left (
    .clk    (clk),
    .load   (en1),
    .cfg    (cfg),
    .sample (s_tdata[31:0]),
    .v16    (left_v16)
  );

  vssc_lane u_lane_right (
    .clk    (clk),
    .load   (en1),
    .cfg    (cfg),
    .sample (s_tdata[63:32]),
    .v16    (right_v16)
  );

  // peak tracking and output register
  vssc_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (v1),
    .in_last     (last1),
    .left_v16    (left_v16),
    .right_v16   (right_v16),
    .cfg         (cfg),
    .in_ready    (merge_ready),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_last    (m_tlast),
    .left_out    (left_out),
    .right_out   (right_out),
    .left_level  (left_level),
    .right_level (right_level)
  );

  assign m_tdata = {2'b00, right_level, left_level, right_out, left_out};

endmodule

// ----- hw/rtl/vssc_checker.sv -----
// port-level checks on the volume scaler top, attached by bind
module vssc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic        m_tlast
);

  // a stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // peak levels are zero except on the last frame of a packet
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[93:64] == 30'd0)
    else $error("peak level reported on a non-final frame");

  // padding bits stay zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[95:94] == 2'b00)
    else $error("output padding not zero");

  // no result right after reset
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // with the output register empty the block takes input
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

endmodule

bind volume_scale_sample_converter_top vssc_checker u_vssc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
